[src/ordered_list_insert_erase_reverse_top_macros.svh]
// Assertion macros used by the checker file.
`ifndef ORDERED_LIST_INSERT_ERASE_REVERSE_TOP_MACROS_SVH
`define ORDERED_LIST_INSERT_ERASE_REVERSE_TOP_MACROS_SVH
// Assert that an implication holds at every clock edge outside reset.
`define OLIR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Assert that a consequence holds in the cycle after the antecedent.
`define OLIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[src/olir_pkg.sv]
// ----------------------------------------------------------------------------
// olir_pkg
// Shared types and codes for the ordered list block.
// ----------------------------------------------------------------------------
package olir_pkg;
  localparam int CAPACITY_DEF = 256;
  localparam int ValW = 32;
  localparam int PosW = 9;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_ERASE = 3'd1;
  localparam logic [2:0] CMD_REVERSE = 3'd2;
  localparam logic [2:0] CMD_FIND = 3'd3;
  localparam logic [2:0] CMD_CHECKSUM = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_BAD_POS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [PosW-1:0] NOT_FOUND_IDX = '1;

  // Operation broadcast to every cell at once.
  typedef enum logic [2:0] {
    OP_HOLD, OP_INS, OP_DEL, OP_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic [ValW-1:0] value;
  } cell_ctl_t;
endpackage

[src/olir_cell.sv]
// ----------------------------------------------------------------------------
// olir_cell
// One list slot: compares with the broadcast value and shifts to neighbors.
// ----------------------------------------------------------------------------
module olir_cell #(
  parameter int IdxW = 8
) (
  input  logic clk,
  input  olir_pkg::cell_ctl_t ctl,
  input  logic [IdxW-1:0] idx,
  input  logic [IdxW:0] ins_pos,
  input  logic [IdxW:0] del_pos,
  input  logic [IdxW:0] len,
  input  logic [31:0] from_lo,
  input  logic [31:0] from_hi,
  output logic [31:0] data,
  output logic match
);
  import olir_pkg::*;
  logic [31:0] data_r, data_nxt;
  logic [IdxW:0] idx_x;

  assign idx_x = {1'b0, idx};
  assign data = data_r;
  assign match = (data_r == ctl.value) && (idx_x < len);

  // Pick the slot's next value from its neighbors or the broadcast.
  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_INS: begin
        if (idx_x == ins_pos) data_nxt = ctl.value;
        else if (idx_x > ins_pos) data_nxt = from_lo;
      end
      OP_DEL: if (idx_x >= del_pos) data_nxt = from_hi;
      OP_ROT: data_nxt = from_hi;
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end
endmodule

[src/olir_ctrl.sv]
// ----------------------------------------------------------------------------
// olir_ctrl
// Sequencer: decodes a request, drives the cell row, builds the result.
// ----------------------------------------------------------------------------
module olir_ctrl #(
  parameter int Capacity = olir_pkg::CAPACITY_DEF,
  parameter int IdxW = $clog2(Capacity)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] command,
  input  logic [8:0] position,
  input  logic [31:0] value,
  input  logic [Capacity-1:0] match,
  input  logic [31:0] head,
  output olir_pkg::cell_ctl_t ctl,
  output logic [IdxW:0] ins_pos,
  output logic [IdxW:0] del_pos,
  output logic [IdxW:0] len,
  output logic res_valid,
  input  logic res_ready,
  output logic [1:0] res_status,
  output logic [8:0] res_idx,
  output logic [31:0] res_sum
);
  import olir_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SUM = 2'd1;
  localparam logic [1:0] S_OUT = 2'd2;
  localparam logic [1:0] S_TAIL = 2'd3;
  localparam int CmpW = (IdxW + 1 > PosW) ? IdxW + 1 : PosW;

  logic [1:0] state_r, state_nxt;
  logic [IdxW:0] len_r, len_nxt, cnt_r, cnt_nxt;
  logic rev_r, rev_nxt;
  logic [1:0] st_r, st_nxt;
  logic [8:0] fi_r, fi_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [IdxW:0] pos_x;
  logic hit;
  logic [IdxW-1:0] first_lo, first_hi;
  logic [IdxW:0] phys, logi, sum_idx;
  logic [31:0] idx32;

  // Priority encode the lowest and the highest matching cell.
  always_comb begin
    hit = 1'b0;
    first_lo = '0;
    first_hi = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit = 1'b1;
        first_lo = IdxW'(i);
      end
    end
    for (int i = 0; i < Capacity; i++) begin
      if (match[i]) first_hi = IdxW'(i);
    end
  end

  // Map list positions onto cells; a reversed list runs from the highest occupied cell down.
  assign pos_x = (IdxW + 1)'(position);
  assign phys = rev_r ? {1'b0, first_hi} : {1'b0, first_lo};
  assign logi = rev_r ? len_r - 1'b1 - phys : phys;
  assign sum_idx = rev_r ? len_r - 1'b1 - cnt_r : cnt_r;
  assign idx32 = 32'(sum_idx);
  assign ins_pos = rev_r ? len_r - pos_x : pos_x;
  assign del_pos = phys;

  assign in_ready = (state_r == S_IDLE);
  assign len = len_r;
  assign res_valid = (state_r == S_OUT);
  assign res_status = st_r;
  assign res_idx = fi_r;
  assign res_sum = sum_r;

  // Decode the request and step the checksum rotation.
  always_comb begin
    state_nxt = state_r;
    len_nxt = len_r;
    cnt_nxt = cnt_r;
    rev_nxt = rev_r;
    st_nxt = st_r;
    fi_nxt = fi_r;
    sum_nxt = sum_r;
    ctl.op = OP_HOLD;
    ctl.value = value;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          st_nxt = ST_OK;
          fi_nxt = NOT_FOUND_IDX;
          sum_nxt = '0;
          state_nxt = S_OUT;
          case (command) inside
            CMD_INSERT: begin
              if (CmpW'(position) > CmpW'(len_r)) st_nxt = ST_BAD_POS;
              else if (len_r == (IdxW + 1)'(Capacity)) st_nxt = ST_FULL;
              else begin
                ctl.op = OP_INS;
                len_nxt = len_r + 1'b1;
              end
            end
            CMD_ERASE, CMD_FIND: begin
              if (!hit) st_nxt = ST_NOT_FOUND;
              else begin
                fi_nxt = 9'(logi);
                if (command == CMD_ERASE) begin
                  ctl.op = OP_DEL;
                  len_nxt = len_r - 1'b1;
                end
              end
            end
            CMD_REVERSE: rev_nxt = ~rev_r;
            CMD_CHECKSUM: begin
              cnt_nxt = '0;
              if (len_r != '0) state_nxt = S_SUM;
            end
            default: ;
          endcase
        end
      end
      S_SUM: begin
        // Accumulate the head cell, then rotate the row down by one.
        sum_nxt = sum_r + (idx32 ^ head);
        ctl.op = OP_ROT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_nxt == len_r) begin
          if (len_r == (IdxW + 1)'(Capacity)) state_nxt = S_OUT;
          else begin
            state_nxt = S_TAIL;
            cnt_nxt = len_r;
          end
        end
      end
      S_TAIL: begin
        // Finish the rotation over the idle tail so order is restored.
        ctl.op = OP_ROT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_nxt == (IdxW + 1)'(Capacity)) state_nxt = S_OUT;
      end
      S_OUT: if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r <= '0;
      rev_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt;
      rev_r <= rev_nxt;
    end
    cnt_r <= cnt_nxt;
    st_r <= st_nxt;
    fi_r <= fi_nxt;
    sum_r <= sum_nxt;
  end
endmodule

[src/ordered_list_insert_erase_reverse_top.sv]
// ----------------------------------------------------------------------------
// ordered_list_insert_erase_reverse_top
// Ordered list held in a row of cells with a small command sequencer.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata fields (low bit up)                      | tuser
// in_     | in  | command[2:0] position[11:3] value[43:12]       | none
// out_    | out | status[1:0] found_index[10:2] checksum[42:11]  | none
// Insert, erase, find, reverse: the result is registered at accept and
// the result register holds it until taken.
// Checksum: a nonempty list turns the row fully after accept (one head
// cell summed per cycle over the list); empty lists skip to the result.
// Reset empties the list and clears the direction flag; cells are not cleared.
// One request at a time; input stalls until the result is taken.
module ordered_list_insert_erase_reverse_top #(
  parameter int Capacity = olir_pkg::CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [47:0] in_tdata,  // command, position, value
  output logic out_tvalid,
  input  logic out_tready,
  output logic [47:0] out_tdata  // status, found_index, checksum
);
  import olir_pkg::*;
  localparam int IdxW = $clog2(Capacity);

  cell_ctl_t ctl;
  logic [IdxW:0] ins_pos, del_pos, len;
  logic [Capacity-1:0] match;
  logic [31:0] data [Capacity];
  logic [1:0] st;
  logic [8:0] fi;
  logic [31:0] sum;

  olir_ctrl #(.Capacity(Capacity), .IdxW(IdxW)) u_ctrl (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .command(in_tdata[2:0]), .position(in_tdata[11:3]), .value(in_tdata[43:12]),
    .match, .head(data[0]), .ctl, .ins_pos, .del_pos, .len,
    .res_valid(out_tvalid), .res_ready(out_tready),
    .res_status(st), .res_idx(fi), .res_sum(sum)
  );

  // Build the cell row; each cell sees both neighbors.
  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    olir_cell #(.IdxW(IdxW)) u_cell (
      .clk, .ctl, .idx(IdxW'(g)), .ins_pos, .del_pos, .len,
      .from_lo(data[(g == 0) ? 0 : g - 1]),
      .from_hi(data[(g == Capacity - 1) ? 0 : g + 1]),
      .data(data[g]), .match(match[g])
    );
  end

  assign out_tdata = {5'd0, sum, fi, st};
endmodule

[src/olir_checker.sv]
// ----------------------------------------------------------------------------
// olir_checker
// Port-level checks on the ordered list block.
// ----------------------------------------------------------------------------
`include "ordered_list_insert_erase_reverse_top_macros.svh"
module olir_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [47:0] out_tdata
);
  import olir_pkg::*;
  `OLIR_ASSERT_IMPL(a_excl, out_tvalid, !in_tready, "request taken while result waits")
  `OLIR_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `OLIR_ASSERT_NEXT(a_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed")
  `OLIR_ASSERT_IMPL(a_fidx, out_tvalid && out_tdata[1:0] == ST_NOT_FOUND, out_tdata[10:2] == NOT_FOUND_IDX, "not found with index")
  `OLIR_ASSERT_IMPL(a_pad, out_tvalid, out_tdata[47:43] == 5'd0, "pad bits set")
endmodule

bind ordered_list_insert_erase_reverse_top olir_checker u_olir_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
